>>> sv/nfce_pkg.sv
// ----------------------------------------------------------------------------
// Nearest free cell escape package
// Shared widths, reset values, word types, codes and sequencer types.
// ----------------------------------------------------------------------------
package nfce_pkg;

   localparam int NFCE_MAX_WIDTH  = 256;
   localparam int NFCE_MAX_HEIGHT = 256;

   localparam int COST_W     = 8;
   localparam int GRID_DIM_W = 9;
   localparam int SPEED_W    = 15;
   localparam int COORD_W    = 8;
   localparam int VEL_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // Largest map dimension the 9-bit size registers can express.
   localparam int DIM_LIMIT = 511;

   localparam logic [COST_W-1:0]     OCC_LIMIT_RESET  = 8'd50;
   localparam logic [COST_W-1:0]     FREE_LIMIT_RESET = 8'd0;
   localparam logic [SPEED_W-1:0]    SPEED_RESET      = 15'd0;
   localparam logic [GRID_DIM_W-1:0] GRID_DIM_RESET   = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OCCUPIED_LIMIT = 3'd0,
      CSR_FREE_LIMIT     = 3'd1,
      CSR_SPEED          = 3'd2,
      CSR_GRID_WIDTH     = 3'd3,
      CSR_GRID_HEIGHT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COST_W-1:0] cell_cost;
      logic              last_cell;
   } req_word_type;

   typedef struct packed {
      logic                    stuck;
      logic                    found;
      logic [COORD_W-1:0]      target_col;
      logic [COORD_W-1:0]      target_row;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_UPD,
      ST_PREP,
      ST_COMP,
      ST_SA,
      ST_USQ,
      ST_T2,
      ST_TD,
      ST_CMP,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_DX,
      MUL_DY,
      MUL_SA,
      MUL_USQ,
      MUL_TT,
      MUL_TD
   } mul_op_type;

   typedef struct packed {
      logic       ready;
      mul_op_type mul_op;
      logic       cap_dx2;
      logic       upd_cell;
      logic       start_final;
      logic       comp_skip;
      logic       comp_start;
      logic       cap_rhs;
      logic       cmp_step;
      logic       load_out;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic last;
      logic escape;
      logic a_zero;
      logic bit_zero;
      logic bit_top;
      logic comp_y;
      logic out_free;
   } status_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

>>> sv/nfce_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, reused for every product
// the block needs: squared offsets, speed scaling and the rounding search.
// ----------------------------------------------------------------------------
module nfce_mul
   import nfce_pkg::*;
#(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic                 clock,
   input  logic [A_W-1:0]       op_a,
   input  logic [B_W-1:0]       op_b,
   output logic [A_W+B_W-1:0]   prod_ff
);

   logic [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> sv/nfce_fsm.sv
// ----------------------------------------------------------------------------
// Escape search sequencer
// Steps each cell through the shared multiplier, then for an escape runs the
// bit-by-bit velocity search for both components, then hands on the result.
// ----------------------------------------------------------------------------
module nfce_fsm
   import nfce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_SQX;
         end
         ST_SQX: state_in = ST_SQY;
         ST_SQY: state_in = ST_UPD;
         ST_UPD: begin
            state_in = status.last ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            state_in = status.escape ? ST_COMP : ST_OUT;
         end
         ST_COMP: begin
            if (!status.a_zero) begin
               state_in = ST_SA;
            end else begin
               state_in = status.comp_y ? ST_OUT : ST_COMP;
            end
         end
         ST_SA:  state_in = ST_USQ;
         ST_USQ: state_in = ST_T2;
         ST_T2:  state_in = ST_TD;
         ST_TD:  state_in = ST_CMP;
         ST_CMP: begin
            if (!status.bit_zero) begin
               state_in = ST_T2;
            end else begin
               state_in = status.comp_y ? ST_OUT : ST_COMP;
            end
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_op = MUL_DX;
      unique case (state_ff)
         ST_IDLE: ctrl.ready = 1'b1;
         ST_SQX:  ctrl.mul_op = MUL_DX;
         ST_SQY: begin
            ctrl.mul_op  = MUL_DY;
            ctrl.cap_dx2 = 1'b1;
         end
         ST_UPD:  ctrl.upd_cell = 1'b1;
         ST_PREP: ctrl.start_final = 1'b1;
         ST_COMP: begin
            ctrl.comp_skip  = status.a_zero;
            ctrl.comp_start = !status.a_zero;
         end
         ST_SA:   ctrl.mul_op = MUL_SA;
         ST_USQ:  ctrl.mul_op = MUL_USQ;
         ST_T2: begin
            ctrl.mul_op  = MUL_TT;
            ctrl.cap_rhs = status.bit_top;
         end
         ST_TD:   ctrl.mul_op = MUL_TD;
         ST_CMP:  ctrl.cmp_step = 1'b1;
         ST_OUT:  ctrl.load_out = status.out_free;
         default: ctrl.ready = 1'b0;
      endcase
   end

endmodule

>>> sv/nearest_free_cell_escape.sv
// ----------------------------------------------------------------------------
// Nearest free cell escape
// Scans a costmap and reports the free cell nearest the centre together
// with an escape velocity toward it.
// ----------------------------------------------------------------------------
// Usage: the costmap streams in on the req_ channel, one cell cost per word
// in row-major order, with last_cell set on the final cell. For each cell
// the word is taken, then the shared multiplier squares the column and row
// offsets and the nearest-cell compare follows. req_stall stays high after
// each accepted word until the block is back in idle.
// After the last cell the block produces one rsp_ word. When the robot is not
// stuck or no free cell was seen, it goes straight to the output register.
// Otherwise each velocity component with a nonzero offset runs a 15-step
// rounding search on the same multiplier, set up in COMP, SA and USQ, with
// each step passing through T2, TD and CMP.
// The result waits in an output register while rsp_stall is high; the next
// map can start streaming in meanwhile, and only the following result waits
// for that register to empty.
// Registers must be written through the csr_ port only while the block is
// idle; the block itself does not enforce this. Synchronous reset restores
// the register defaults, clears the scan state and drops rsp_valid.
// ----------------------------------------------------------------------------
module nearest_free_cell_escape
   import nfce_pkg::*;
#(
   parameter int MAX_WIDTH  = NFCE_MAX_WIDTH,
   parameter int MAX_HEIGHT = NFCE_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int EW  = (MAX_WIDTH  < DIM_LIMIT) ? MAX_WIDTH  : DIM_LIMIT;
   localparam int EH  = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
   localparam int CW  = $clog2(EW);
   localparam int RW  = $clog2(EH);
   localparam int AW  = max_int(CW, RW);
   localparam int DW  = 2 * AW + 1;
   localparam int TW  = SPEED_W + 1;
   localparam int UW  = SPEED_W + 1 + AW;
   localparam int MA  = max_int(2 * TW, UW);
   localparam int MB  = max_int(DW, UW);
   localparam int PW  = MA + MB;
   localparam int SBW = $clog2(SPEED_W);
   localparam logic [GRID_DIM_W-1:0] W_CAP   = GRID_DIM_W'(EW);
   localparam logic [GRID_DIM_W-1:0] H_CAP   = GRID_DIM_W'(EH);
   localparam logic [SBW-1:0]        BIT_TOP = SBW'(SPEED_W - 1);

   // Configuration registers.
   logic [COST_W-1:0]     occ_limit_ff;
   logic [COST_W-1:0]     free_limit_ff;
   logic [SPEED_W-1:0]    speed_ff;
   logic [GRID_DIM_W-1:0] grid_w_ff;
   logic [GRID_DIM_W-1:0] grid_h_ff;

   // Scan state.
   logic [CW-1:0]     col_ff;
   logic [RW-1:0]     row_ff;
   logic [COST_W-1:0] centre_ff;
   logic [DW-1:0]     best_d2_ff;
   logic [CW-1:0]     best_col_ff;
   logic [RW-1:0]     best_row_ff;
   logic              found_ff;

   // Per-cell and final-phase working registers.
   logic [COST_W-1:0] cost_ff;
   logic              last_ff;
   logic [DW-1:0]     dx2_ff;
   logic              comp_ff;
   logic [SBW-1:0]    bit_ff;
   logic [SPEED_W-1:0] m_ff;
   logic [2*UW-1:0]   rhs_ff;
   logic [VEL_W-1:0]  vx_ff;
   logic [VEL_W-1:0]  vy_ff;
   logic              stuck_ff;
   logic              esc_ff;

   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   ctrl_type   ctrl;
   status_type status;

   logic [MA-1:0] mul_a;
   logic [MB-1:0] mul_b;
   logic [PW-1:0] prod_ff;

   logic [GRID_DIM_W-1:0] w_eff;
   logic [GRID_DIM_W-1:0] h_eff;
   logic [CW-1:0]         cx;
   logic [RW-1:0]         cy;
   logic [CW-1:0]         adx;
   logic [RW-1:0]         ady;
   logic                  bx_neg;
   logic                  by_neg;
   logic [CW-1:0]         abx;
   logic [RW-1:0]         aby;
   logic [AW-1:0]         a_cur;
   logic                  neg_cur;
   logic [DW-1:0]         d2_cur;
   logic                  take_best;
   logic                  col_wrap;
   logic                  row_wrap;
   logic                  out_free;
   logic [SPEED_W-1:0]    cand;
   logic [TW-1:0]         t_val;
   logic [UW-1:0]         u_val;
   logic [SPEED_W-1:0]    m_next;
   logic [VEL_W-1:0]      vel_mag;
   logic [VEL_W-1:0]      vel_rec;
   logic                  record;
   logic                  req_take;

   // Effective map size: zero counts as one, large values clamp to the cap.
   always_comb begin
      priority if (grid_w_ff == '0) begin
         w_eff = GRID_DIM_W'(1);
      end else if (grid_w_ff > W_CAP) begin
         w_eff = W_CAP;
      end else begin
         w_eff = grid_w_ff;
      end
      priority if (grid_h_ff == '0) begin
         h_eff = GRID_DIM_W'(1);
      end else if (grid_h_ff > H_CAP) begin
         h_eff = H_CAP;
      end else begin
         h_eff = grid_h_ff;
      end
   end

   assign cx = CW'(w_eff >> 1);
   assign cy = RW'(h_eff >> 1);

   assign adx = (col_ff < cx) ? (cx - col_ff) : (col_ff - cx);
   assign ady = (row_ff < cy) ? (cy - row_ff) : (row_ff - cy);

   assign bx_neg  = best_col_ff < cx;
   assign by_neg  = best_row_ff < cy;
   assign abx     = bx_neg ? (cx - best_col_ff) : (best_col_ff - cx);
   assign aby     = by_neg ? (cy - best_row_ff) : (best_row_ff - cy);
   assign a_cur   = comp_ff ? AW'(aby) : AW'(abx);
   assign neg_cur = comp_ff ? by_neg : bx_neg;

   assign req_take = req_valid && ctrl.ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Candidate for the current bit of the rounded magnitude; t = 2 * cand - 1.
   assign cand   = m_ff | (SPEED_W'(1) << bit_ff);
   assign t_val  = {cand, 1'b0} - TW'(1);
   assign u_val  = {prod_ff[UW-2:0], 1'b0};
   assign m_next = (prod_ff <= PW'(rhs_ff)) ? cand : m_ff;

   assign vel_mag = VEL_W'(ctrl.comp_skip ? '0 : m_next);
   assign vel_rec = neg_cur ? (~vel_mag + VEL_W'(1)) : vel_mag;
   assign record  = ctrl.comp_skip || (ctrl.cmp_step && status.bit_zero);

   assign d2_cur    = dx2_ff + DW'(prod_ff);
   assign take_best = (cost_ff <= free_limit_ff) && (!found_ff || (d2_cur < best_d2_ff));
   assign col_wrap  = ((GRID_DIM_W+1)'(col_ff) + (GRID_DIM_W+1)'(1))
                      >= (GRID_DIM_W+1)'(w_eff);
   assign row_wrap  = ((GRID_DIM_W+1)'(row_ff) + (GRID_DIM_W+1)'(1))
                      >= (GRID_DIM_W+1)'(h_eff);

   always_comb begin
      status.req_valid = req_valid;
      status.last      = last_ff;
      status.escape    = (centre_ff > occ_limit_ff) && found_ff;
      status.a_zero    = (a_cur == '0);
      status.bit_zero  = (bit_ff == '0);
      status.bit_top   = (bit_ff == BIT_TOP);
      status.comp_y    = comp_ff;
      status.out_free  = out_free;
   end

   always_comb begin
      unique case (ctrl.mul_op)
         MUL_DX: begin
            mul_a = MA'(adx);
            mul_b = MB'(adx);
         end
         MUL_DY: begin
            mul_a = MA'(ady);
            mul_b = MB'(ady);
         end
         MUL_SA: begin
            mul_a = MA'(speed_ff);
            mul_b = MB'(a_cur);
         end
         MUL_USQ: begin
            mul_a = MA'(u_val);
            mul_b = MB'(u_val);
         end
         MUL_TT: begin
            mul_a = MA'(t_val);
            mul_b = MB'(t_val);
         end
         MUL_TD: begin
            mul_a = MA'(prod_ff[2*TW-1:0]);
            mul_b = MB'(best_d2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   nfce_mul #(
      .A_W (MA),
      .B_W (MB)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   nfce_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_limit_ff  <= OCC_LIMIT_RESET;
         free_limit_ff <= FREE_LIMIT_RESET;
         speed_ff      <= SPEED_RESET;
         grid_w_ff     <= GRID_DIM_RESET;
         grid_h_ff     <= GRID_DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OCCUPIED_LIMIT: occ_limit_ff  <= csr_wdata[COST_W-1:0];
            CSR_FREE_LIMIT:     free_limit_ff <= csr_wdata[COST_W-1:0];
            CSR_SPEED:          speed_ff      <= csr_wdata[SPEED_W-1:0];
            CSR_GRID_WIDTH:     grid_w_ff     <= csr_wdata[GRID_DIM_W-1:0];
            CSR_GRID_HEIGHT:    grid_h_ff     <= csr_wdata[GRID_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Scan state: centre capture, nearest cell tracking and cell counters.
   always_ff @(posedge clock) begin
      if (reset || ctrl.load_out) begin
         col_ff      <= '0;
         row_ff      <= '0;
         centre_ff   <= '0;
         best_d2_ff  <= '1;
         best_col_ff <= '0;
         best_row_ff <= '0;
         found_ff    <= 1'b0;
      end else begin
         if (req_take && (col_ff == cx) && (row_ff == cy)) begin
            centre_ff <= req_data.cell_cost;
         end
         if (ctrl.upd_cell) begin
            if (take_best) begin
               best_d2_ff  <= d2_cur;
               best_col_ff <= col_ff;
               best_row_ff <= row_ff;
               found_ff    <= 1'b1;
            end
            if (col_wrap) begin
               col_ff <= '0;
               row_ff <= row_wrap ? '0 : (row_ff + RW'(1));
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cost_ff <= req_data.cell_cost;
         last_ff <= req_data.last_cell;
      end
      if (ctrl.cap_dx2) begin
         dx2_ff <= DW'(prod_ff);
      end
      if (ctrl.cap_rhs) begin
         rhs_ff <= prod_ff[2*UW-1:0];
      end
      if (ctrl.start_final) begin
         stuck_ff <= centre_ff > occ_limit_ff;
         esc_ff   <= status.escape;
      end
      if (record) begin
         if (comp_ff) begin
            vy_ff <= vel_rec;
         end else begin
            vx_ff <= vel_rec;
         end
      end
   end

   // Rounding search over the velocity magnitude, one bit per step.
   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= 1'b0;
         bit_ff  <= '0;
         m_ff    <= '0;
      end else begin
         if (ctrl.start_final) begin
            comp_ff <= 1'b0;
         end else if (record) begin
            comp_ff <= !comp_ff;
         end
         if (ctrl.comp_start) begin
            m_ff   <= '0;
            bit_ff <= BIT_TOP;
         end else if (ctrl.cmp_step) begin
            m_ff <= m_next;
            if (!status.bit_zero) begin
               bit_ff <= bit_ff - SBW'(1);
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         rsp_data_ff.stuck      <= stuck_ff;
         rsp_data_ff.found      <= esc_ff;
         rsp_data_ff.target_col <= esc_ff ? COORD_W'(best_col_ff) : '0;
         rsp_data_ff.target_row <= esc_ff ? COORD_W'(best_row_ff) : '0;
         rsp_data_ff.vel_x      <= esc_ff ? vx_ff : '0;
         rsp_data_ff.vel_y      <= esc_ff ? vy_ff : '0;
      end
   end

   assign req_stall = !ctrl.ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/nfce_checker.sv
// ----------------------------------------------------------------------------
// Nearest free cell escape checker
// Port-level properties of the escape search, bound to the top level.
// ----------------------------------------------------------------------------
module nfce_checker
   import nfce_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // An escape target is reported only when the robot is stuck.
   a_found_stuck: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.stuck)
      else $error("found set without stuck");

   // Without a target, the target and velocity fields are zero.
   a_no_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.target_col == '0 && rsp_data.target_row == '0 &&
         rsp_data.vel_x == '0 && rsp_data.vel_y == '0)
      else $error("nonzero target or velocity without a found cell");

   // Each cell occupies the multiplier, so the block is busy right after taking a word.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word taken on consecutive cycles");

endmodule

bind nearest_free_cell_escape nfce_checker u_nfce_checker (.*);

>>> test/escape_checker.sv
// ----------------------------------------------------------------------------
// Nearest free cell escape checker
// Follows the register writes and the accepted cell words, predicts the
// escape word of every map and compares each accepted result word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module escape_checker
   import nfce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_word_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    results_owed
);

   logic [COST_W-1:0]     occ_limit;
   logic [COST_W-1:0]     free_limit;
   logic [SPEED_W-1:0]    speed;
   logic [GRID_DIM_W-1:0] width_reg;
   logic [GRID_DIM_W-1:0] height_reg;

   int unsigned       scan_col;
   int unsigned       scan_row;
   logic [COST_W-1:0] centre_cost;
   int unsigned       best_d2;
   int unsigned       best_col;
   int unsigned       best_row;
   bit                free_seen;

   int           errors;
   rsp_word_type escape_q[$];

   function automatic int unsigned usable_dim(input logic [GRID_DIM_W-1:0] raw,
                                              input int unsigned ceiling);
      if (raw == 0) return 1;
      if (raw > ceiling) return ceiling;
      return raw;
   endfunction

   // Magnitude of spd * a / sqrt(d2), rounded with ties going up. The test
   // (2m-1)^2 * d2 <= 4 * spd^2 * a^2 holds for every m up to the answer,
   // so the answer can be built one bit at a time from the top.
   function automatic int heading_share(input int unsigned spd, input int unsigned a,
                                        input int unsigned d2);
      longint unsigned bound;
      longint unsigned odd;
      int unsigned     mag;
      int unsigned     trial;
      bound = 64'd4 * spd * spd * a * a;
      mag = 0;
      for (int b = SPEED_W - 1; b >= 0; b--) begin
         trial = mag | (32'd1 << b);
         odd = 2 * trial - 1;
         if (trial <= spd && odd * odd * d2 <= bound) mag = trial;
      end
      return int'(mag);
   endfunction

   function automatic void clear_scan();
      scan_col = 0;
      scan_row = 0;
      centre_cost = '0;
      best_d2 = 32'h1FFFF;
      best_col = 0;
      best_row = 0;
      free_seen = 1'b0;
   endfunction

   function automatic void absorb_word(input req_word_type word);
      int unsigned  cols;
      int unsigned  rows;
      int unsigned  cx;
      int unsigned  cy;
      int unsigned  d2;
      int           dx;
      int           dy;
      int           mag;
      rsp_word_type escape;
      cols = usable_dim(width_reg, NFCE_MAX_WIDTH);
      rows = usable_dim(height_reg, NFCE_MAX_HEIGHT);
      cx = cols / 2;
      cy = rows / 2;
      if (scan_col == cx && scan_row == cy) centre_cost = word.cell_cost;
      if (word.cell_cost <= free_limit) begin
         dx = int'(scan_col) - int'(cx);
         dy = int'(scan_row) - int'(cy);
         d2 = dx * dx + dy * dy;
         // Only a strictly closer cell replaces the one already kept.
         if (!free_seen || d2 < best_d2) begin
            best_d2 = d2;
            best_col = scan_col;
            best_row = scan_row;
            free_seen = 1'b1;
         end
      end
      if (scan_col + 1 >= cols) begin
         scan_col = 0;
         scan_row = (scan_row + 1 >= rows) ? 0 : scan_row + 1;
      end else begin
         scan_col++;
      end
      if (word.last_cell) begin
         escape = '0;
         escape.stuck = centre_cost > occ_limit;
         if (escape.stuck && free_seen) begin
            escape.found = 1'b1;
            escape.target_col = COORD_W'(best_col);
            escape.target_row = COORD_W'(best_row);
            dx = int'(best_col) - int'(cx);
            dy = int'(best_row) - int'(cy);
            if (dx != 0) begin
               mag = heading_share(speed, (dx < 0) ? -dx : dx, best_d2);
               escape.vel_x = VEL_W'((dx < 0) ? -mag : mag);
            end
            if (dy != 0) begin
               mag = heading_share(speed, (dy < 0) ? -dy : dy, best_d2);
               escape.vel_y = VEL_W'((dy < 0) ? -mag : mag);
            end
         end
         escape_q.push_back(escape);
         clear_scan();
      end
   endfunction

   task automatic note_mismatch(input string what, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      errors++;
      if (errors <= 10) begin
         $display("mismatch at %0t in %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         occ_limit = OCC_LIMIT_RESET;
         free_limit = FREE_LIMIT_RESET;
         speed = SPEED_RESET;
         width_reg = GRID_DIM_RESET;
         height_reg = GRID_DIM_RESET;
         clear_scan();
         escape_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OCCUPIED_LIMIT: occ_limit = csr_wdata[COST_W-1:0];
               CSR_FREE_LIMIT:     free_limit = csr_wdata[COST_W-1:0];
               CSR_SPEED:          speed = csr_wdata[SPEED_W-1:0];
               CSR_GRID_WIDTH:     width_reg = csr_wdata[GRID_DIM_W-1:0];
               CSR_GRID_HEIGHT:    height_reg = csr_wdata[GRID_DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) absorb_word(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (escape_q.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch at %0t: result word %h arrived with none expected",
                           $time, rsp_data);
               end
            end else begin
               want = escape_q.pop_front();
               if (rsp_data.stuck !== want.stuck)
                  note_mismatch("stuck", want.stuck, rsp_data.stuck);
               if (rsp_data.found !== want.found)
                  note_mismatch("found", want.found, rsp_data.found);
               if (rsp_data.target_col !== want.target_col)
                  note_mismatch("target_col", want.target_col, rsp_data.target_col);
               if (rsp_data.target_row !== want.target_row)
                  note_mismatch("target_row", want.target_row, rsp_data.target_row);
               if (rsp_data.vel_x !== want.vel_x)
                  note_mismatch("vel_x", want.vel_x, rsp_data.vel_x);
               if (rsp_data.vel_y !== want.vel_y)
                  note_mismatch("vel_y", want.vel_y, rsp_data.vel_y);
            end
         end
      end
      mismatch_count <= errors;
      results_owed <= escape_q.size();
   end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Nearest free cell escape testbench
// Streams directed and random costmaps through the block under a range of
// register settings, with random gaps on the cell side and random stalls on
// the result side; the checker beside the block predicts every escape word.
// ----------------------------------------------------------------------------
module tb_top;
   import nfce_pkg::*;

   localparam int ITEM_TARGET    = 2000;
   localparam int CALM_AFTER     = ITEM_TARGET * 9 / 10;
   localparam int FLUSH_CYCLES   = 110;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          mismatch_count;
   int          results_owed;
   int unsigned items_sent;
   bit          calm;
   bit          gaps_on;
   int unsigned idle_cycles;
   int unsigned stall_run;

   // Generator copy of the current map shape and limits, used to size maps and bias costs.
   int unsigned       map_cols;
   int unsigned       map_rows;
   logic [COST_W-1:0] map_occ;
   logic [COST_W-1:0] map_free;

   always #1 clock = ~clock;

   nearest_free_cell_escape i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   escape_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // Result side: random stall bursts between free-running stretches.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 60);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [COST_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return COST_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_cell(input logic [COST_W-1:0] cost, input logic last);
      if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cell_cost: cost, last_cell: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (items_sent >= CALM_AFTER) calm <= 1'b1;
   endtask

   // Drops valid and waits until every escape word is back and the block has
   // had time to finish any cell still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [COST_W-1:0] occ, input logic [COST_W-1:0] free,
                               input logic [SPEED_W-1:0] spd,
                               input logic [GRID_DIM_W-1:0] cols,
                               input logic [GRID_DIM_W-1:0] rows);
      csr_we <= 1'b1;
      csr_index <= CSR_OCCUPIED_LIMIT;
      csr_wdata <= CSR_DATA_W'(occ);
      @(posedge clock);
      csr_index <= CSR_FREE_LIMIT;
      csr_wdata <= CSR_DATA_W'(free);
      @(posedge clock);
      csr_index <= CSR_SPEED;
      csr_wdata <= CSR_DATA_W'(spd);
      @(posedge clock);
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= CSR_DATA_W'(cols);
      @(posedge clock);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= CSR_DATA_W'(rows);
      @(posedge clock);
      csr_we <= 1'b0;
      map_occ = occ;
      map_free = free;
      map_cols = (cols == 0) ? 1 : (cols > NFCE_MAX_WIDTH) ? NFCE_MAX_WIDTH : cols;
      map_rows = (rows == 0) ? 1 : (rows > NFCE_MAX_HEIGHT) ? NFCE_MAX_HEIGHT : rows;
   endtask

   // The centre cell is mostly made occupied so that the search result matters.
   task automatic send_map(input int unsigned cells, input int unsigned free_pct,
                           input bit closed);
      int unsigned       col;
      int unsigned       row;
      logic [COST_W-1:0] cost;
      for (int unsigned k = 0; k < cells; k++) begin
         col = k % map_cols;
         row = (k / map_cols) % map_rows;
         if (col == map_cols / 2 && row == map_rows / 2 && map_occ != '1 &&
             $urandom_range(0, 3) != 0) begin
            cost = COST_W'($urandom_range(int'(map_occ) + 1, 255));
         end else if ($urandom_range(0, 99) < free_pct) begin
            cost = COST_W'($urandom_range(0, int'(map_free)));
         end else if (map_free != '1) begin
            cost = COST_W'($urandom_range(int'(map_free) + 1, 255));
         end else begin
            cost = COST_W'($urandom_range(0, 255));
         end
         send_cell(cost, closed && (k == cells - 1));
      end
   endtask

   initial begin
      int unsigned          phase;
      int unsigned          maps;
      int unsigned          cells;
      logic [GRID_DIM_W-1:0] cols_raw;
      logic [GRID_DIM_W-1:0] rows_raw;
      logic [SPEED_W-1:0]    spd;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;

      // 3x3 map, speed 256.
      program_regs(8'd50, 8'd0, 15'd256, 9'd3, 9'd3);
      // Stuck, with the only free cell in the top left corner.
      for (int k = 0; k < 9; k++) begin
         send_cell((k == 0) ? 8'd0 : (k == 4) ? 8'd255 : 8'd200, k == 8);
      end
      // The map ends before the centre is reached, so it is not stuck.
      send_cell(8'd0, 1'b1);
      // Stuck with no free cell at all.
      for (int k = 0; k < 9; k++) begin
         send_cell(COST_W'(128 + k), k == 8);
      end
      settle();

      // Zero width and height act as a single cell; everything counts as free.
      program_regs(8'd0, 8'd255, 15'h7FFF, 9'd0, 9'd0);
      // The nearest free cell is the centre itself.
      send_cell(8'd255, 1'b1);
      // More cells than the map holds, all landing on the same coordinate.
      send_cell(8'd9, 1'b0);
      send_cell(8'd0, 1'b0);
      send_cell(8'd7, 1'b1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         settle();
         phase++;
         if (phase == 1) begin
            cols_raw = ($urandom_range(0, 2) == 0) ? 9'd300 :
                       ($urandom_range(0, 1) == 0) ? 9'd511 : 9'd256;
            rows_raw = GRID_DIM_W'($urandom_range(1, 2));
            maps = 1;
         end else if (phase == 2) begin
            cols_raw = GRID_DIM_W'($urandom_range(1, 2));
            rows_raw = ($urandom_range(0, 1) == 0) ? 9'd511 : 9'd256;
            maps = 1;
         end else begin
            cols_raw = GRID_DIM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) :
                                                                  $urandom_range(1, 8));
            rows_raw = GRID_DIM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) :
                                                                  $urandom_range(1, 8));
            maps = $urandom_range(2, 8);
         end
         case ($urandom_range(0, 4))
            0: spd = '0;
            1: spd = '1;
            default: spd = SPEED_W'($urandom_range(0, 32767));
         endcase
         program_regs(pick_limit(), pick_limit(), spd, cols_raw, rows_raw);
         for (int m = 0; m < maps; m++) begin
            gaps_on = $urandom_range(0, 3) != 0;
            cells = map_cols * map_rows;
            // Now and then a map of the wrong length, sometimes left unterminated.
            if (cells <= 64 && $urandom_range(0, 7) == 0) begin
               send_map($urandom_range(1, 2 * cells + 2), $urandom_range(0, 40),
                        $urandom_range(0, 1) == 1);
            end else begin
               send_map(cells, (cells > 64) ? $urandom_range(0, 3) : $urandom_range(0, 40),
                        1'b1);
            end
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
